>>> rtl/fpa_pkg.sv
// fpa_pkg: widths, opcodes and the pipeline stage record shared by the Q17.14 ALU.
// No dependencies; compiled first.
package fpa_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 4;
    localparam int PROD_W        = 2 * DATA_W;
    // dividend width: operand magnitude pre-scaled by the fraction bits
    localparam int DIV_W         = DATA_W + FRACTION_BITS;

    // scale minus one, the bias that turns a floor shift into truncation toward zero
    localparam logic [DATA_W-1:0] SCALE_M1 = DATA_W'((64'd1 << FRACTION_BITS) - 64'd1);
    localparam logic [PROD_W-1:0] SCALE_M1_W = PROD_W'((64'd1 << FRACTION_BITS) - 64'd1);

    typedef enum logic [OP_W-1:0] {
        OP_TOINT  = 4'd0,
        OP_TOFIX  = 4'd1,
        OP_ADD    = 4'd2,
        OP_SUB    = 4'd3,
        OP_ADDINT = 4'd4,
        OP_SUBINT = 4'd5,
        OP_MUL    = 4'd6,
        OP_MULINT = 4'd7,
        OP_DIV    = 4'd8,
        OP_DIVINT = 4'd9
    } t_op;

    // how the final value of an item is formed
    typedef enum logic [1:0] {
        K_PLAIN  = 2'd0,   // value already in res
        K_MUL    = 2'd1,   // scaled fixed-point product
        K_MULINT = 2'd2,   // low word of product
        K_DIV    = 2'd3    // quotient from the divider
    } t_kind;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic              neg;    // quotient sign
        logic              dz;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] rem;    // partial remainder, below den for divide items
        logic [DIV_W-1:0]  quo;    // dividend bits shifting out, quotient bits in
        logic [DATA_W-1:0] den;    // divisor magnitude
    } t_stage;

endpackage

>>> rtl/fpa_if.sv
// fpa_req_if / fpa_rsp_if: valid/ready channels of the Q17.14 ALU.
// Depends on fpa_pkg for widths.
interface fpa_req_if;
    logic                                    valid;
    logic                                    ready;
    logic        [fpa_pkg::OP_W-1:0]         op;
    logic signed [fpa_pkg::DATA_W-1:0]       operand_a;
    logic signed [fpa_pkg::DATA_W-1:0]       operand_b;

    modport source (output valid, op, operand_a, operand_b, input ready);
    modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [fpa_pkg::DATA_W-1:0]       result_value;
    logic                                    divide_by_zero;

    modport source (output valid, result_value, divide_by_zero, input ready);
    modport sink   (input valid, result_value, divide_by_zero, output ready);
endinterface

>>> rtl/fpa_div_stage.sv
// fpa_div_stage: one registered restoring-division step (one quotient bit).
// Depends on fpa_pkg.
module fpa_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fpa_pkg::t_stage i_st,
    output fpa_pkg::t_stage o_st
);

    fpa_pkg::t_stage               n_st;
    fpa_pkg::t_stage               r_st;
    logic [fpa_pkg::DATA_W:0]      w_trial;
    logic [fpa_pkg::DATA_W:0]      w_diff;
    logic                          w_ge;

    // shift next dividend bit into the remainder, subtract divisor if it fits
    always_comb begin
        w_trial = {i_st.rem, i_st.quo[fpa_pkg::DIV_W-1]};
        w_diff  = w_trial - {1'b0, i_st.den};
        w_ge    = (w_trial >= {1'b0, i_st.den});
        n_st    = i_st;
        if (i_st.kind == fpa_pkg::K_DIV) begin
            n_st.rem = w_ge ? w_diff[fpa_pkg::DATA_W-1:0] : w_trial[fpa_pkg::DATA_W-1:0];
            n_st.quo = {i_st.quo[fpa_pkg::DIV_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st.valid <= n_st.valid;
        end
        if (i_en) begin
            r_st.kind <= n_st.kind;
            r_st.neg  <= n_st.neg;
            r_st.dz   <= n_st.dz;
            r_st.res  <= n_st.res;
            r_st.rem  <= n_st.rem;
            r_st.quo  <= n_st.quo;
            r_st.den  <= n_st.den;
        end
    end

    assign o_st = r_st;

endmodule

>>> rtl/fixed_point_17_14_alu.sv
// fixed_point_17_14_alu: pipelined Q17.14 fixed-point ALU, top level.
// Depends on fpa_pkg, fpa_req_if / fpa_rsp_if and fpa_div_stage.
//
//  channel | dir | modport | payload
//  i_req   | in  | sink    | op[3:0], operand_a[31:0], operand_b[31:0]
//  o_rsp   | out | source  | result_value[31:0], divide_by_zero
//
// Every op runs through all stages; one item is taken per cycle unless the pipe holds.
// The depth comes from the divider: one quotient bit per stage over a
// 46-bit pre-scaled dividend, plus a prep/multiply stage and the output register.
// Reset (synchronous, active low) clears the valid bits of all stages.
// When an output item waits, the whole pipe holds and i_req.ready drops.
module fixed_point_17_14_alu (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fpa_req_if.sink  i_req,
    fpa_rsp_if.source o_rsp
);

    localparam int DW  = fpa_pkg::DATA_W;
    localparam int FB  = fpa_pkg::FRACTION_BITS;
    localparam int QW  = fpa_pkg::DIV_W;
    localparam int PW  = fpa_pkg::PROD_W;

    logic                    w_adv;

    // prep stage
    fpa_pkg::t_stage         n_s0;
    fpa_pkg::t_stage         r_s0;
    logic signed [PW-1:0]    n_prod;
    logic signed [PW-1:0]    r_prod;
    logic signed [DW-1:0]    w_a;
    logic signed [DW-1:0]    w_b;
    logic [DW-1:0]           w_mag_a;
    logic [DW-1:0]           w_mag_b;
    logic signed [DW-1:0]    w_toint_sum;

    // product fix-up feeding the divider chain
    fpa_pkg::t_stage         n_fix;
    logic [PW-1:0]           w_prod_sum;

    fpa_pkg::t_stage         w_chain [0:QW];

    // output register
    logic                    r_out_valid;
    logic [DW-1:0]           r_out_res;
    logic                    r_out_dz;
    logic [DW-1:0]           n_out_res;
    logic [DW-1:0]           w_q;

    // pipe moves when the output register is free or being emptied
    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_adv;

    // decode, simple ops, multiplier and divider operand setup
    always_comb begin
        w_a         = i_req.operand_a;
        w_b         = i_req.operand_b;
        w_mag_a     = w_a[DW-1] ? (DW'(0) - DW'(w_a)) : DW'(w_a);
        w_mag_b     = w_b[DW-1] ? (DW'(0) - DW'(w_b)) : DW'(w_b);
        w_toint_sum = w_a + $signed(w_a[DW-1] ? fpa_pkg::SCALE_M1 : DW'(0));
        n_prod      = PW'(w_a) * PW'(w_b);

        n_s0.valid = i_req.valid;
        n_s0.kind  = fpa_pkg::K_PLAIN;
        n_s0.neg   = w_a[DW-1] ^ w_b[DW-1];
        n_s0.dz    = 1'b0;
        n_s0.res   = '0;
        n_s0.rem   = '0;
        n_s0.quo   = '0;
        n_s0.den   = w_mag_b;
        case (fpa_pkg::t_op'(i_req.op))
            fpa_pkg::OP_TOINT:  n_s0.res = DW'(w_toint_sum >>> FB);
            fpa_pkg::OP_TOFIX:  n_s0.res = DW'(w_a) << FB;
            fpa_pkg::OP_ADD:    n_s0.res = DW'(w_a) + DW'(w_b);
            fpa_pkg::OP_SUB:    n_s0.res = DW'(w_a) - DW'(w_b);
            fpa_pkg::OP_ADDINT: n_s0.res = DW'(w_a) + (DW'(w_b) << FB);
            fpa_pkg::OP_SUBINT: n_s0.res = DW'(w_a) - (DW'(w_b) << FB);
            fpa_pkg::OP_MUL:    n_s0.kind = fpa_pkg::K_MUL;
            fpa_pkg::OP_MULINT: n_s0.kind = fpa_pkg::K_MULINT;
            fpa_pkg::OP_DIV: begin
                if (w_mag_b == '0) begin
                    n_s0.dz = 1'b1;
                end else begin
                    n_s0.kind = fpa_pkg::K_DIV;
                    n_s0.quo  = {w_mag_a, FB'(0)};
                end
            end
            fpa_pkg::OP_DIVINT: begin
                if (w_mag_b == '0) begin
                    n_s0.dz = 1'b1;
                end else begin
                    n_s0.kind = fpa_pkg::K_DIV;
                    n_s0.quo  = QW'(w_mag_a);
                end
            end
            default: n_s0.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_adv) begin
            r_s0.valid <= n_s0.valid;
        end
        if (w_adv) begin
            r_s0.kind <= n_s0.kind;
            r_s0.neg  <= n_s0.neg;
            r_s0.dz   <= n_s0.dz;
            r_s0.res  <= n_s0.res;
            r_s0.rem  <= n_s0.rem;
            r_s0.quo  <= n_s0.quo;
            r_s0.den  <= n_s0.den;
            r_prod    <= n_prod;
        end
    end

    // product truncated toward zero by the scale, or its low word
    always_comb begin
        w_prod_sum = PW'(r_prod) + (r_prod[PW-1] ? fpa_pkg::SCALE_M1_W : PW'(0));
        n_fix      = r_s0;
        case (r_s0.kind)
            fpa_pkg::K_MUL:    n_fix.res = w_prod_sum[FB+DW-1:FB];
            fpa_pkg::K_MULINT: n_fix.res = r_prod[DW-1:0];
            default:           n_fix.res = r_s0.res;
        endcase
    end

    // divider chain, one quotient bit per stage
    assign w_chain[0] = n_fix;

    for (genvar k = 0; k < QW; k++) begin : g_div
        fpa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_st    (w_chain[k]),
            .o_st    (w_chain[k+1])
        );
    end

    // sign the quotient, low word wraps
    always_comb begin
        w_q       = w_chain[QW].quo[DW-1:0];
        n_out_res = w_chain[QW].res;
        if (w_chain[QW].kind == fpa_pkg::K_DIV) begin
            n_out_res = w_chain[QW].neg ? (DW'(0) - w_q) : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_chain[QW].valid;
        end
        if (w_adv) begin
            r_out_res <= n_out_res;
            r_out_dz  <= w_chain[QW].dz;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_value   = r_out_res;
    assign o_rsp.divide_by_zero = r_out_dz;

    // a divide-by-zero item always yields a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_dz |-> r_out_res == '0)
        else $error("divide-by-zero item with nonzero result");

    // only a divide op raises the flag; at the prep stage a flagged item is plain with a zero result
    a_dz_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0.valid && r_s0.dz |-> r_s0.kind == fpa_pkg::K_PLAIN && r_s0.res == '0)
        else $error("divide-by-zero flag on a non-divide path");

    // a stall freezes the pipe front and the waiting output item
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_s0.valid) && $stable(r_out_res) && r_out_valid)
        else $error("pipeline moved during a stall");

endmodule
